// ===== hw/rtl/ps2mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  // Byte the mouse sends to acknowledge a command
  localparam logic [7:0] ACK_BYTE = 8'hFA;

  // Bit positions inside the flags byte
  localparam int LEFT_BIT   = 0;
  localparam int RIGHT_BIT  = 1;
  localparam int MIDDLE_BIT = 2;
  localparam int ALIGN_BIT  = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;
  localparam int X_OVF_BIT  = 6;
  localparam int Y_OVF_BIT  = 7;

  // Configuration registers
  localparam int LIMIT_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 2'd1;
  localparam logic [LIMIT_W-1:0]   X_LIMIT_RST = 10'd79;
  localparam logic [LIMIT_W-1:0]   Y_LIMIT_RST = 10'd199;

  // Packet status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_APPLIED    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW   = 2'd2;

  // Depth of the packet queue between front and back
  localparam int PKT_Q_DEPTH = 2;

  // One assembled three-byte packet
  typedef struct packed {
    logic [7:0] flags;
    logic [7:0] x_delta;
    logic [7:0] y_delta;
  } pkt_t;

  // Packet queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/ps2mpt_front.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_front
// Byte assembler: drops a leading acknowledge byte, gathers flags, X and Y
// bytes and pushes each complete packet into the packet queue.
// ----------------------------------------------------------------------------
module ps2mpt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [7:0]          in_rx_byte,
  output logic                in_full,
  input  ps2mpt_pkg::q_stat_t q_stat,
  output logic                q_push,
  output ps2mpt_pkg::pkt_t    q_pkt
);
  import ps2mpt_pkg::*;

  // Byte position codes
  localparam logic [1:0] POS_FLAGS = 2'd0;
  localparam logic [1:0] POS_X     = 2'd1;
  localparam logic [1:0] POS_Y     = 2'd2;

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic [7:0] x_delta_r, x_delta_nxt;
  logic       accept;

  assign in_full = q_stat.full;
  assign accept  = in_push && !in_full;

  // Packet handed to the queue on the Y byte
  assign q_pkt.flags   = flags_r;
  assign q_pkt.x_delta = x_delta_r;
  assign q_pkt.y_delta = in_rx_byte;

  // Byte position sequencer
  always_comb begin
    pos_nxt     = pos_r;
    flags_nxt   = flags_r;
    x_delta_nxt = x_delta_r;
    q_push      = 1'b0;
    if (accept) begin
      unique case (pos_r)
        POS_X: begin
          x_delta_nxt = in_rx_byte;
          pos_nxt     = POS_Y;
        end
        POS_Y: begin
          q_push  = 1'b1;
          pos_nxt = POS_FLAGS;
        end
        default: begin
          // flags slot; the unused code behaves the same
          pos_nxt = POS_FLAGS;
          if (in_rx_byte != ACK_BYTE) begin
            flags_nxt = in_rx_byte;
            pos_nxt   = POS_X;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_FLAGS;
      flags_r   <= '0;
      x_delta_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      flags_r   <= flags_nxt;
      x_delta_r <= x_delta_nxt;
    end
  end

endmodule

// ===== hw/rtl/ps2mpt_pkt_queue.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_pkt_queue
// Small packet FIFO that decouples the byte assembler from the cursor unit.
// ----------------------------------------------------------------------------
module ps2mpt_pkt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ps2mpt_pkg::pkt_t    push_pkt,
  input  logic                pop,
  output ps2mpt_pkg::pkt_t    head_pkt,
  output ps2mpt_pkg::q_stat_t stat
);
  import ps2mpt_pkg::*;

  localparam int PW = (PKT_Q_DEPTH > 1) ? $clog2(PKT_Q_DEPTH) : 1;
  localparam int CNTW = $clog2(PKT_Q_DEPTH + 1);
  localparam logic [PW-1:0]   LAST_PTR = PW'(PKT_Q_DEPTH - 1);
  localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(PKT_Q_DEPTH);

  pkt_t            mem_r [PKT_Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (count_r == DEPTH_CNT);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_pkt   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

// ===== hw/rtl/ps2mpt_back.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_back
// Cursor unit: checks each packet, moves and clamps the cursor and holds the
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
module ps2mpt_back #(
  parameter int POS_WIDTH = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ps2mpt_pkg::q_stat_t                q_stat,
  input  ps2mpt_pkg::pkt_t                   q_head,
  output logic                               q_pop,
  input  logic [ps2mpt_pkg::LIMIT_W-1:0]     x_limit,
  input  logic [ps2mpt_pkg::LIMIT_W-1:0]     y_limit,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic [ps2mpt_pkg::LIMIT_W-1:0]     out_pos_x,
  output logic [ps2mpt_pkg::LIMIT_W-1:0]     out_pos_y,
  output logic                               out_left_pressed,
  output logic                               out_middle_pressed,
  output logic                               out_right_pressed,
  output logic [ps2mpt_pkg::STATUS_W-1:0]    out_packet_status
);
  import ps2mpt_pkg::*;

  // Working width: holds cursor, limit and a signed 9-bit delta
  localparam int CW = ((POS_WIDTH > LIMIT_W) ? POS_WIDTH : LIMIT_W) + 2;
  localparam logic [CW-1:0] POS_MAX = CW'((64'd1 << POS_WIDTH) - 64'd1);

  // Clamp a signed sum to 0..ceiling
  function automatic logic [POS_WIDTH-1:0] clamp_pos(
    input logic signed [CW-1:0] v,
    input logic [CW-1:0]        lim
  );
    logic [CW-1:0] ceil_v;
    logic [CW-1:0] res;
    ceil_v = (lim < POS_MAX) ? lim : POS_MAX;
    if (v < 0) begin
      res = '0;
    end else if ($unsigned(v) > ceil_v) begin
      res = ceil_v;
    end else begin
      res = $unsigned(v);
    end
    return res[POS_WIDTH-1:0];
  endfunction

  // Cursor to 10-bit result field
  function automatic logic [LIMIT_W-1:0] to_field(input logic [POS_WIDTH-1:0] p);
    logic [CW-1:0] e;
    e = CW'(p);
    return e[LIMIT_W-1:0];
  endfunction

  logic [POS_WIDTH-1:0]  cur_x_r, cur_y_r;
  logic                  out_valid_r;
  logic [LIMIT_W-1:0]    pos_x_r, pos_y_r;
  logic                  left_r, middle_r, right_r;
  logic [STATUS_W-1:0]   status_r;

  logic [STATUS_W-1:0]   status;
  logic signed [CW-1:0]  dx, dy, sum_x, sum_y;
  logic [POS_WIDTH-1:0]  new_x, new_y;
  logic                  take;

  // Packet check
  always_comb begin
    if (!q_head.flags[ALIGN_BIT]) begin
      status = STATUS_MISALIGNED;
    end else if (q_head.flags[X_OVF_BIT] || q_head.flags[Y_OVF_BIT]) begin
      status = STATUS_OVERFLOW;
    end else begin
      status = STATUS_APPLIED;
    end
  end

  // Move and clamp
  assign dx    = CW'($signed({q_head.flags[X_SIGN_BIT], q_head.x_delta}));
  assign dy    = CW'($signed({q_head.flags[Y_SIGN_BIT], q_head.y_delta}));
  assign sum_x = $signed(CW'(cur_x_r)) + dx;
  assign sum_y = $signed(CW'(cur_y_r)) - dy;
  assign new_x = clamp_pos(sum_x, CW'(x_limit));
  assign new_y = clamp_pos(sum_y, CW'(y_limit));

  // Take a packet when the output register is free or being emptied
  assign take  = !q_stat.empty && (!out_valid_r || out_pop);
  assign q_pop = take;

  // Cursor and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        if (status == STATUS_APPLIED) begin
          cur_x_r <= new_x;
          cur_y_r <= new_y;
        end
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      pos_x_r  <= (status == STATUS_APPLIED) ? to_field(new_x) : to_field(cur_x_r);
      pos_y_r  <= (status == STATUS_APPLIED) ? to_field(new_y) : to_field(cur_y_r);
      left_r   <= q_head.flags[LEFT_BIT];
      middle_r <= q_head.flags[MIDDLE_BIT];
      right_r  <= q_head.flags[RIGHT_BIT];
      status_r <= status;
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_pos_x          = pos_x_r;
  assign out_pos_y          = pos_y_r;
  assign out_left_pressed   = left_r;
  assign out_middle_pressed = middle_r;
  assign out_right_pressed  = right_r;
  assign out_packet_status  = status_r;

endmodule

// ===== hw/rtl/ps2_mouse_packet_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Follows a PS/2 mouse byte stream, decodes three-byte packets and keeps a
// clamped cursor position.
// ----------------------------------------------------------------------------
//  channel  | ports                                          | transaction when
//  ---------+------------------------------------------------+-------------------
//  input    | in_push, in_full, in_rx_byte                   | in_push && !in_full
//  result   | out_pop, out_empty, out_pos_x/_y, out_*_pressed,| out_pop && !out_empty
//           | out_packet_status                              |
//  config   | cfg_we, cfg_index, cfg_wdata                   | cfg_we
//
// One byte is taken per cycle while in_full is low. The edge that takes a
// packet's Y byte writes it into the packet queue; the cursor unit's output
// register loads it from the queue head once free or being emptied. The cursor
// adder and clamp handle one packet per cycle unless the result port stalls.
// Reset (rst_n low, synchronous) clears the cursor and byte position and
// loads the limits with 79 and 199. No clearing pass.
// A stalled result port backs up the two-entry packet queue; in_full rises
// only when that queue is full.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
  parameter int POS_WIDTH = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input bytes
  input  logic                               in_push,
  input  logic [7:0]                         in_rx_byte,
  output logic                               in_full,
  // results
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic [ps2mpt_pkg::LIMIT_W-1:0]     out_pos_x,
  output logic [ps2mpt_pkg::LIMIT_W-1:0]     out_pos_y,
  output logic                               out_left_pressed,
  output logic                               out_middle_pressed,
  output logic                               out_right_pressed,
  output logic [ps2mpt_pkg::STATUS_W-1:0]    out_packet_status,
  // configuration
  input  logic                               cfg_we,
  input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ps2mpt_pkg::LIMIT_W-1:0]     cfg_wdata
);
  import ps2mpt_pkg::*;

  logic [LIMIT_W-1:0] x_limit_r, y_limit_r;
  q_stat_t            q_stat;
  pkt_t               q_pkt, q_head;
  logic               q_push, q_pop;

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_X_LIMIT) begin
        x_limit_r <= cfg_wdata;
      end else if (cfg_index == REG_Y_LIMIT) begin
        y_limit_r <= cfg_wdata;
      end
    end
  end

  // Byte assembler
  ps2mpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_pkt      (q_pkt)
  );

  // Packet queue
  ps2mpt_pkt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pkt (q_pkt),
    .pop      (q_pop),
    .head_pkt (q_head),
    .stat     (q_stat)
  );

  // Cursor unit
  ps2mpt_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .x_limit            (x_limit_r),
    .y_limit            (y_limit_r),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_left_pressed   (out_left_pressed),
    .out_middle_pressed (out_middle_pressed),
    .out_right_pressed  (out_right_pressed),
    .out_packet_status  (out_packet_status)
  );

  // Checks
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("packet pushed into full queue");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_push && !in_full))
    else $error("packet pushed without a byte transaction");

  a_applied_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_packet_status == STATUS_APPLIED) |->
      (out_pos_x <= x_limit_r && out_pos_y <= y_limit_r))
    else $error("applied cursor outside its limits");

  a_pop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_empty)
    else $error("packet taken from queue but no result held");

endmodule

// ===== test/ps2_mouse_packet_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_checker
// Watches the byte, report and register ports of the packet tracker. It keeps
// its own copy of the packet state, cursor and limits, predicts one report per
// completed packet, and compares every popped report against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_checker #(
  parameter int POS_WIDTH = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // byte channel
  input  logic                               in_push,
  input  logic                               in_full,
  input  logic [7:0]                         in_rx_byte,
  // report channel
  input  logic                               out_pop,
  input  logic                               out_empty,
  input  logic [ps2mpt_pkg::LIMIT_W-1:0]     out_pos_x,
  input  logic [ps2mpt_pkg::LIMIT_W-1:0]     out_pos_y,
  input  logic                               out_left_pressed,
  input  logic                               out_middle_pressed,
  input  logic                               out_right_pressed,
  input  logic [ps2mpt_pkg::STATUS_W-1:0]    out_packet_status,
  // register port
  input  logic                               cfg_we,
  input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ps2mpt_pkg::LIMIT_W-1:0]     cfg_wdata,
  // summary for the top
  output int                                 fail_count,
  output int                                 results_owed,
  output int                                 n_applied,
  output int                                 n_misaligned,
  output int                                 n_overflow
);
  import ps2mpt_pkg::*;

  localparam int POS_MAX    = (1 << POS_WIDTH) - 1;
  localparam int MAX_REPORT = 10;

  typedef enum logic [1:0] {AWAIT_FLAGS, AWAIT_X, AWAIT_Y} pkt_phase_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  pos_x;
    logic [LIMIT_W-1:0]  pos_y;
    logic                left_btn;
    logic                middle_btn;
    logic                right_btn;
    logic [STATUS_W-1:0] status;
  } report_t;

  // predicted reports, oldest first
  report_t              expected_reports[$];

  // tracker state as predicted
  pkt_phase_t           phase;
  logic [7:0]           flags_hold;
  logic [7:0]           x_hold;
  logic [POS_WIDTH-1:0] cur_x;
  logic [POS_WIDTH-1:0] cur_y;
  logic [LIMIT_W-1:0]   lim_x;
  logic [LIMIT_W-1:0]   lim_y;

  int fails;
  int reported;
  int cnt_applied;
  int cnt_misaligned;
  int cnt_overflow;

  initial begin
    fails          = 0;
    reported       = 0;
    cnt_applied    = 0;
    cnt_misaligned = 0;
    cnt_overflow   = 0;
  end

  // Delta byte widened with the sign bit carried in the flags byte
  function automatic int signed_delta(input logic [7:0] b, input logic neg);
    return neg ? int'(b) - 256 : int'(b);
  endfunction

  // Ceiling is the smaller of the limit and the cursor's full scale
  function automatic logic [POS_WIDTH-1:0] clamp_axis(input int v,
                                                      input logic [LIMIT_W-1:0] lim);
    int ceiling;
    ceiling = (int'(lim) < POS_MAX) ? int'(lim) : POS_MAX;
    if (v < 0) return '0;
    if (v > ceiling) return POS_WIDTH'(ceiling);
    return POS_WIDTH'(v);
  endfunction

  task automatic reset_model();
    phase      = AWAIT_FLAGS;
    flags_hold = '0;
    x_hold     = '0;
    cur_x      = '0;
    cur_y      = '0;
    lim_x      = X_LIMIT_RST;
    lim_y      = Y_LIMIT_RST;
    expected_reports.delete();
  endtask

  // Advance the packet state by one byte; the Y byte yields a report
  task automatic take_byte(input logic [7:0] b);
    report_t r;
    int      nx;
    int      ny;
    case (phase)
      AWAIT_X: begin
        x_hold = b;
        phase  = AWAIT_Y;
      end
      AWAIT_Y: begin
        phase        = AWAIT_FLAGS;
        r.left_btn   = flags_hold[LEFT_BIT];
        r.middle_btn = flags_hold[MIDDLE_BIT];
        r.right_btn  = flags_hold[RIGHT_BIT];
        if (!flags_hold[ALIGN_BIT]) begin
          r.status = STATUS_MISALIGNED;
        end else if (flags_hold[X_OVF_BIT] || flags_hold[Y_OVF_BIT]) begin
          r.status = STATUS_OVERFLOW;
        end else begin
          // x moves with the delta, y against it (screen y grows downward)
          nx       = int'(cur_x) + signed_delta(x_hold, flags_hold[X_SIGN_BIT]);
          ny       = int'(cur_y) - signed_delta(b, flags_hold[Y_SIGN_BIT]);
          cur_x    = clamp_axis(nx, lim_x);
          cur_y    = clamp_axis(ny, lim_y);
          r.status = STATUS_APPLIED;
        end
        r.pos_x = LIMIT_W'(cur_x);
        r.pos_y = LIMIT_W'(cur_y);
        expected_reports.push_back(r);
      end
      default: begin
        // acknowledge is only dropped where a packet would start
        phase = AWAIT_FLAGS;
        if (b != ACK_BYTE) begin
          flags_hold = b;
          phase      = AWAIT_X;
        end
      end
    endcase
  endtask

  task automatic check_report(input report_t got);
    report_t exp;
    if (expected_reports.size() == 0) begin
      fails++;
      if (reported < MAX_REPORT)
        $display("%0t: report with nothing predicted: x=%0d y=%0d btn=%b%b%b st=%0d",
                 $realtime, got.pos_x, got.pos_y, got.left_btn, got.middle_btn,
                 got.right_btn, got.status);
      reported++;
    end else begin
      exp = expected_reports.pop_front();
      case (exp.status)
        STATUS_APPLIED:    cnt_applied++;
        STATUS_MISALIGNED: cnt_misaligned++;
        default:           cnt_overflow++;
      endcase
      if (got !== exp) begin
        fails++;
        if (reported < MAX_REPORT)
          $display({"%0t: mismatch: expected x=%0d y=%0d l/m/r=%b%b%b st=%0d,",
                    " got x=%0d y=%0d l/m/r=%b%b%b st=%0d"},
                   $realtime, exp.pos_x, exp.pos_y, exp.left_btn, exp.middle_btn,
                   exp.right_btn, exp.status, got.pos_x, got.pos_y, got.left_btn,
                   got.middle_btn, got.right_btn, got.status);
        reported++;
      end
    end
  endtask

  // Sample all channels at the rising edge; the summary outputs are registered
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_X_LIMIT: lim_x = cfg_wdata;
          REG_Y_LIMIT: lim_y = cfg_wdata;
          default: ;
        endcase
      end
      if (out_pop && !out_empty)
        check_report({out_pos_x, out_pos_y, out_left_pressed, out_middle_pressed,
                      out_right_pressed, out_packet_status});
      if (in_push && !in_full)
        take_byte(in_rx_byte);
    end
    fail_count   <= fails;
    results_owed <= expected_reports.size();
    n_applied    <= cnt_applied;
    n_misaligned <= cnt_misaligned;
    n_overflow   <= cnt_overflow;
  end

endmodule

// ===== test/tb_ps2_mouse_packet_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_tracker
// Drives mouse byte streams into the packet tracker: a short directed run
// over acknowledge handling, sign and overflow flags, misalignment and
// clamping, then random packet traffic with noise under several limit
// settings. Both channels stall at random; the checker scores the reports.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_tracker;
  import ps2mpt_pkg::*;

  localparam int POS_W           = 10;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RAND_PHASES     = 6;
  localparam int BYTES_PER_PHASE = 255;
  localparam int GAP_MAX         = 16;

  // register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic [7:0]           in_rx_byte;
  logic                 in_full;
  logic                 out_pop = 1'b0;
  logic                 out_empty;
  logic [LIMIT_W-1:0]   out_pos_x;
  logic [LIMIT_W-1:0]   out_pos_y;
  logic                 out_left_pressed;
  logic                 out_middle_pressed;
  logic                 out_right_pressed;
  logic [STATUS_W-1:0]  out_packet_status;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_wdata;

  int fail_count;
  int results_owed;
  int n_applied;
  int n_misaligned;
  int n_overflow;

  int src_gap_max   = GAP_MAX;
  int snk_gap_max   = GAP_MAX;
  int snk_wait      = 0;
  int bytes_sent    = 0;
  int settings_used = 1;

  ps2_mouse_packet_tracker #(.POS_WIDTH(POS_W)) dut (.*);

  ps2_mouse_packet_tracker_checker #(.POS_WIDTH(POS_W)) u_checker (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Report side: after each transaction hold pop low for a random stall
  always @(posedge clk) begin : sink
    int stall;
    if (!rst_n) begin
      out_pop  <= 1'b0;
      snk_wait <= 0;
    end else if (out_pop && !out_empty) begin
      stall = $urandom_range(snk_gap_max, 0);
      if (stall == 0) begin
        out_pop <= 1'b1;
      end else begin
        out_pop  <= 1'b0;
        snk_wait <= stall - 1;
      end
    end else if (!out_pop) begin
      if (snk_wait == 0) out_pop <= 1'b1;
      else snk_wait <= snk_wait - 1;
    end
  end

  // One byte transaction, preceded by a random gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_byte(flags);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Stop sending until every predicted report has been popped
  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Limits change only with the tracker idle; one stray index is written too
  task automatic set_limits(input logic [LIMIT_W-1:0] xl, input logic [LIMIT_W-1:0] yl);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_X_LIMIT;
    cfg_wdata <= xl;
    @(posedge clk);
    cfg_index <= REG_Y_LIMIT;
    cfg_wdata <= yl;
    @(posedge clk);
    cfg_index <= ($urandom_range(1, 0) != 0) ? REG_SPARE_2 : REG_SPARE_3;
    cfg_wdata <= LIMIT_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Deltas lean toward the byte extremes
  function automatic logic [7:0] pick_delta();
    case ($urandom_range(7, 0))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed packets; some acknowledges, stray bytes and pauses
  task automatic random_traffic(input int n_bytes);
    int         stop_at;
    int         pick;
    logic [7:0] flags;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) begin
        send_byte(8'($urandom));
      end else if (pick < 12) begin
        send_byte(ACK_BYTE);
      end else if (pick < 13) begin
        drain_results();
      end else begin
        flags            = 8'($urandom);
        flags[ALIGN_BIT] = ($urandom_range(9, 0) != 0);
        if ($urandom_range(7, 0) != 0) begin
          flags[X_OVF_BIT] = 1'b0;
          flags[Y_OVF_BIT] = 1'b0;
        end
        send_packet(flags, pick_delta(), pick_delta());
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_push    <= 1'b0;
    in_rx_byte <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_X_LIMIT;
    cfg_wdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset limits of 79 and 199 are in force
    send_byte(ACK_BYTE);                 // dropped at packet start
    send_packet(8'h0F, ACK_BYTE, ACK_BYTE); // acknowledge taken as delta data
    send_packet(8'h3F, 8'h80, 8'h80);    // both signs, deltas of -128
    send_packet(8'h08, 8'h7F, 8'h7F);    // deltas of +127, x clamps high
    send_packet(8'hC7, 8'h01, 8'h01);    // misaligned and overflow together
    send_packet(8'h4D, 8'h05, 8'h05);    // x overflow
    send_packet(8'h8A, 8'h05, 8'h05);    // y overflow
    send_packet(8'h00, 8'h00, 8'h00);    // misaligned, all zero
    send_packet(8'hFF, 8'hFF, 8'hFF);    // all ones

    // Limit lowered under the cursor: rejected packet keeps it, applied clamps
    set_limits(10'd10, 10'd0);
    send_packet(8'h48, 8'h00, 8'h00);
    send_packet(8'h08, 8'h00, 8'h00);

    // Random traffic over zero, full-scale and random limits
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       set_limits('0, '0);
        1:       set_limits('1, '1);
        2:       set_limits('1, '0);
        3:       set_limits('0, '1);
        default: set_limits(LIMIT_W'($urandom_range(1023, 0)),
                            LIMIT_W'($urandom_range(1023, 0)));
      endcase
      src_gap_max = (ph % 3 == 1) ? 0 : GAP_MAX;
      snk_gap_max = (ph % 3 == 2) ? 0 : GAP_MAX;
      random_traffic(BYTES_PER_PHASE);
    end

    drain_results();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d bytes; checked %0d reports (%0d applied, %0d misaligned, %0d overflow)",
             bytes_sent, n_applied + n_misaligned + n_overflow, n_applied, n_misaligned,
             n_overflow);
    $display("Covered %0d limit settings incl. zero and full scale, random stalls on both ports",
             settings_used);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb_ps2_mouse_packet_tracker OK");
    end else begin
      $display("tb_ps2_mouse_packet_tracker NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("tb_ps2_mouse_packet_tracker NOT OK");
    $finish;
  end

endmodule
